### hw/rtl/sst_pkg.sv
// shared constants and elaboration helpers for the square scytale transposition core
package sst_pkg;

  // default message store depth in bytes
  localparam int DEFAULT_CAPACITY = 64;

  // fill byte for grid positions past the end of the message
  localparam logic [7:0] PAD_BYTE = 8'h20;

  // smallest side s with s*s >= n, evaluated at elaboration
  function automatic int square_side(input int n);
    int k;
    k = 0;
    for (int s = 0; s <= n; s++) begin
      if (s * s < n) begin
        k = s + 1;
      end
    end
    return k;
  endfunction

endpackage

### hw/rtl/scytale_square_transposition_core.sv
// top level of the square scytale transposition core: byte store, side search and readout
//
// Message bytes stream in at one transfer per cycle and are written into a synchronous
// byte store with one write port and one registered read port; bytes past CAPACITY are
// dropped. The transfer that carries end_of_message starts the readout: first the grid
// side k (smallest k with k*k >= n) is found by stepping k up one per cycle, then k*k
// result bytes are sent in column-major order, with a space wherever the position lies
// past the message. Only one store read is in flight at a time: each registered store
// read feeds the output register, and a new read waits until the previous one has landed
// and the output register is free. Input stall is high from the final byte until the
// last store read has been issued; the next message may load while the final results
// still drain. The store has no reset and needs no clearing pass, since only positions
// written during the current message ever reach a result.
module scytale_square_transposition_core #(
  parameter int CAPACITY = sst_pkg::DEFAULT_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_in,
  input  logic       end_of_message,
  input  logic       char_valid,
  output logic       char_stall,
  output logic [7:0] char_out,
  output logic       last_out,
  output logic       result_valid,
  input  logic       result_stall
);

  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SIDE_MAX = sst_pkg::square_side(CAPACITY);
  localparam int SIDE_W   = $clog2(SIDE_MAX + 1);
  localparam int PROD_W   = 2 * SIDE_W;
  localparam int CMP_W    = PROD_W + CNT_W;

  typedef enum logic [1:0] {
    LOAD,
    SIDE,
    READ
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    msg_len;
  logic [SIDE_W-1:0]   side;
  logic [SIDE_W-1:0]   col;
  logic [SIDE_W-1:0]   row;
  logic                rd_pend;
  logic                pend_pad;
  logic                pend_last;
  logic [7:0]          mem_q;
  logic [7:0]          mem [CAPACITY];

  logic                in_xfer;
  logic                room;
  logic                wr_en;
  logic [PROD_W-1:0]   side_sq;
  logic [PROD_W-1:0]   row_off;
  logic [PROD_W-1:0]   pos;
  logic                pos_pad;
  logic                grid_last;
  logic                row_end;
  logic                issue;
  logic                side_short;

  // input handshake and store write enable
  assign char_stall = (state != LOAD);
  assign in_xfer    = char_valid && !char_stall;
  assign room       = (count < CNT_W'(CAPACITY));
  assign wr_en      = in_xfer && room;

  // side search compare
  assign side_sq    = PROD_W'(side) * PROD_W'(side);
  assign side_short = (CMP_W'(side_sq) < CMP_W'(msg_len));

  // readout position: output (col, row) takes stored byte row*k + col
  assign row_off   = PROD_W'(row) * PROD_W'(side);
  assign pos       = row_off + PROD_W'(col);
  assign pos_pad   = (CMP_W'(pos) >= CMP_W'(msg_len));
  assign row_end   = (row == side - SIDE_W'(1));
  assign grid_last = row_end && (col == side - SIDE_W'(1));

  // one read in flight, issued only when the output register is free
  assign issue = (state == READ) && !rd_pend && (!result_valid || !result_stall);

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[ADDR_W-1:0]] <= char_in;
    end
    if (issue) begin
      mem_q <= mem[pos[ADDR_W-1:0]];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      count        <= '0;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // land the pending read into the output register
      if (rd_pend) begin
        char_out     <= pend_pad ? sst_pkg::PAD_BYTE : mem_q;
        last_out     <= pend_last;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      rd_pend <= issue;
      if (issue) begin
        pend_pad  <= pos_pad;
        pend_last <= grid_last;
      end

      unique case (state)
        LOAD: begin
          if (in_xfer) begin
            if (end_of_message) begin
              msg_len <= room ? count + CNT_W'(1) : count;
              count   <= '0;
              side    <= '0;
              state   <= SIDE;
            end else if (room) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        SIDE: begin
          if (side_short) begin
            side <= side + SIDE_W'(1);
          end else begin
            col   <= '0;
            row   <= '0;
            state <= READ;
          end
        end
        READ: begin
          if (issue) begin
            if (grid_last) begin
              state <= LOAD;
            end else if (row_end) begin
              row <= '0;
              col <= col + SIDE_W'(1);
            end else begin
              row <= row + SIDE_W'(1);
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a pending read always lands as a valid result
  a_land: assert property (@(posedge clk) disable iff (rst) rd_pend |=> result_valid)
    else $error("pending read did not reach the output register");

  // a read is never issued into a held output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(issue && result_valid && result_stall))
    else $error("read issued while the output register is held");

  // the fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // the last grid read returns the core to loading
  a_last_to_load: assert property (@(posedge clk) disable iff (rst)
    issue && grid_last |=> state == LOAD)
    else $error("readout did not end after the last grid position");

  // readout always has a nonzero side
  a_side_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == READ |-> side != '0)
    else $error("readout with zero side");
`endif

endmodule
